[design/linear_probe_hash_table_assert.svh]
// Assertion macros shared by the hash table checker
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst is high
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst is high
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lpht_pkg.sv]
// Package: types, codes and defaults for the linear probing hash table
`timescale 1ns / 1ps

package lpht_pkg;

  // defaults for the top-level parameters
  localparam int TABLE_SIZE_DEF = 16;
  localparam int KEY_WIDTH_DEF  = 16;

  // fixed beat field widths
  localparam int IN_KEY_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 4;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic                op;
    logic [IN_KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
  } rsp_t;

endpackage

[design/lpht_ram.sv]
// Generic single-port RAM with registered read data
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read (old data on a same-address write)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/linear_probe_hash_table.sv]
// A request passes through S_HASH (home slot) and S_ISSUE (home read), then S_PROBE probes 1 to
// TABLE_SIZE slots, one RAM read per probe, before the result is registered. req_stall stays
// high until the result is registered. The slot RAM has a single port, so probes are strictly
// one slot per cycle. Reset: synchronous; afterwards a clearing pass marks every slot empty,
// req_stall stays high until it ends. A waiting result does not block a new request.
`timescale 1ns / 1ps

module linear_probe_hash_table #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
  parameter int KEY_WIDTH  = lpht_pkg::KEY_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lpht_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output lpht_pkg::rsp_t rsp
);

  import lpht_pkg::*;

  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int RAM_W      = KEY_WIDTH + 1;
  // key mod TABLE_SIZE via exact reciprocal for 16-bit dividends
  localparam int HASH_SHIFT = IN_KEY_W + SLOT_W;
  localparam int RECIP_W    = IN_KEY_W + 2;
  localparam int PROD_W     = IN_KEY_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << HASH_SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [IN_KEY_W-1:0] KEY_MASK =
    IN_KEY_W'(64'hFFFF_FFFF_FFFF_FFFF >> (64 - KEY_WIDTH));
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_ISSUE,
    S_PROBE
  } state_t;

  state_t              state;
  logic                op;
  logic [IN_KEY_W-1:0] key_h;
  logic [PROD_W-1:0]   prod;
  logic [SLOT_W-1:0]   home;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   clr_cnt;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_addr;
  logic [RAM_W-1:0]    ram_wdata;
  logic [RAM_W-1:0]    ram_rdata;

  logic [KEY_WIDTH-1:0] key_w;
  logic [IN_KEY_W-1:0]  quo;
  logic [IN_KEY_W-1:0]  quo_t;
  logic [SLOT_W-1:0]    home_calc;
  logic                 entry_valid;
  logic [KEY_WIDTH-1:0] entry_key;
  logic [SLOT_W-1:0]    slot_nxt;
  logic                 wrap;
  logic                 key_hit;
  logic                 done;
  logic                 rsp_free;
  rsp_t                 result;

  // key as stored and compared
  assign key_w = KEY_WIDTH'(key_h);

  // home slot: key - floor(key * RECIP >> SHIFT) * TABLE_SIZE
  assign quo       = IN_KEY_W'(prod >> HASH_SHIFT);
  assign quo_t     = IN_KEY_W'(quo * IN_KEY_W'(TABLE_SIZE));
  assign home_calc = SLOT_W'(key_h - quo_t);

  // probe evaluation on the slot read last cycle
  assign entry_valid = ram_rdata[KEY_WIDTH];
  assign entry_key   = ram_rdata[KEY_WIDTH-1:0];
  assign slot_nxt    = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  assign wrap        = (slot_nxt == home);
  assign key_hit     = entry_valid && (entry_key == key_w);
  assign done        = !entry_valid || ((op == OP_LOOKUP) && key_hit) || wrap;
  assign rsp_free    = !rsp_valid || !rsp_stall;

  assign req_stall = (state != S_IDLE);

  // result of a finishing probe
  always_comb begin
    result.status = STATUS_MISS;
    result.slot   = '0;
    priority if (!entry_valid) begin
      if (op == OP_INSERT) begin
        result.status = STATUS_OK;
        result.slot   = SLOT_OUT_W'(slot);
      end
    end else if ((op == OP_LOOKUP) && key_hit) begin
      result.status = STATUS_OK;
      result.slot   = SLOT_OUT_W'(slot);
    end else if (op == OP_INSERT) begin
      result.status = STATUS_FULL;
    end
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot;
    ram_wdata = {1'b1, key_w};
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = {1'b0, key_w};
      end
      S_ISSUE: begin
        ram_addr = home;
      end
      S_PROBE: begin
        if (done) begin
          // re-read the same slot while the result waits, so the data holds
          ram_addr = slot;
          ram_we   = rsp_free && (op == OP_INSERT) && !entry_valid;
        end else begin
          ram_addr = slot_nxt;
        end
      end
      default: begin
        ram_addr = slot;
      end
    endcase
  end

  // sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op    <= req.op;
            key_h <= req.key & KEY_MASK;
            prod  <= PROD_W'(req.key & KEY_MASK) * PROD_W'(RECIP);
            state <= S_HASH;
          end
        end
        S_HASH: begin
          home  <= home_calc;
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          slot  <= home;
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (done) begin
            if (rsp_free) begin
              rsp_valid <= 1'b1;
              rsp       <= result;
              state     <= S_IDLE;
            end
          end else begin
            slot <= slot_nxt;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  lpht_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_SIZE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

[design/lpht_checker.sv]
// Port-level checker for the hash table, bound to the top level
`timescale 1ns / 1ps
`include "linear_probe_hash_table_assert.svh"

module lpht_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input lpht_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input lpht_pkg::rsp_t rsp
);

  import lpht_pkg::*;

  // a stalled request beat holds
  `LPHT_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req), "req changed")

  // a stalled result beat holds
  `LPHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed")

  // only the three defined status codes leave the block
  `LPHT_ASSERT_NOW(a_status_code, rsp_valid, rsp.status <= STATUS_FULL, "undefined status code")

  // misses and full-table results carry slot zero
  `LPHT_ASSERT_NOW(a_slot_zero, rsp_valid && (rsp.status != STATUS_OK), rsp.slot == '0, "slot not zero")

  // straight after reset the clearing pass holds off requests and no result is shown
  `LPHT_ASSERT_NOW(a_post_reset, $past(rst), req_stall && !rsp_valid, "block not quiet after reset")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

[test/linear_probe_hash_table_tb.sv]
// Testbench for the linear probing hash table: random and directed beats against a local model
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam int SLOTS          = TABLE_SIZE_DEF;
  localparam int RANDOM_BEATS   = 1035;
  localparam int STALL_LIMIT    = 1000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // local copy of the table contents
  logic [IN_KEY_W-1:0] table_keys [SLOTS];
  bit                  table_used [SLOTS];

  req_t pending_reqs  [$];
  rsp_t expected_rsps [$];
  logic [IN_KEY_W-1:0] known_keys [$];
  int   planned_inserts = 0;
  int   error_count     = 0;
  int   quiet_cycles    = 0;
  int   req_gap_left    = 0;
  int   req_burst_left  = 0;
  int   rsp_hold_left   = 0;
  int   rsp_burst_left  = 0;

  linear_probe_hash_table uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Apply one beat to the local table and return the result it should give
  function automatic rsp_t probe_table(req_t beat);
    rsp_t res;
    int   home;
    int   s;
    home = int'(beat.key) % SLOTS;
    s    = home;
    res  = '{status: STATUS_MISS, slot: '0};
    if (beat.op == OP_LOOKUP) begin
      forever begin
        if (!table_used[s]) break;
        if (table_keys[s] == beat.key) begin
          res = '{status: STATUS_OK, slot: s[SLOT_OUT_W-1:0]};
          break;
        end
        s = (s + 1) % SLOTS;
        if (s == home) break;
      end
    end else begin
      res.status = STATUS_FULL;
      forever begin
        if (!table_used[s]) begin
          table_keys[s] = beat.key;
          table_used[s] = 1'b1;
          res = '{status: STATUS_OK, slot: s[SLOT_OUT_W-1:0]};
          break;
        end
        s = (s + 1) % SLOTS;
        if (s == home) break;
      end
    end
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int draw_idle();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_req(logic op, logic [IN_KEY_W-1:0] key);
    pending_reqs.push_back('{op: op, key: key});
    if (op == OP_INSERT && planned_inserts < SLOTS) begin
      known_keys.push_back(key);
      planned_inserts++;
    end
  endtask

  // Driver: presents queued beats, holds them while stalled
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(probe_table(req));
        if (req_burst_left > 0) begin
          req_burst_left--;
          req_gap_left = 0;
        end else if ($urandom_range(99) < 3) begin
          req_burst_left = $urandom_range(20, 60);
          req_gap_left   = 0;
        end else begin
          req_gap_left = draw_idle();
        end
      end
      if (req_valid && req_stall) begin
        req_valid <= 1'b1;
      end else if (req_gap_left > 0) begin
        req_gap_left--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result beat against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d slot %0d",
                   $time, rsp.status, rsp.slot);
          error_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, rsp.status);
            error_count++;
          end
          if (rsp.slot !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d, got %0d",
                     $time, want.slot, rsp.slot);
            error_count++;
          end
        end
      end
      // receiver back-pressure
      if (rsp_hold_left > 0) begin
        rsp_hold_left--;
        rsp_stall <= 1'b1;
      end else if (rsp_burst_left > 0) begin
        rsp_burst_left--;
        rsp_stall <= 1'b0;
      end else if ($urandom_range(99) < 3) begin
        rsp_burst_left = $urandom_range(20, 80);
        rsp_stall <= 1'b0;
      end else if ($urandom_range(99) < 25) begin
        rsp_hold_left = draw_idle();
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int                  r;
    logic                op;
    logic [IN_KEY_W-1:0] key;
    logic [1:0]          nib_sel;

    // directed: empty table, wrap from the last slot, chains, duplicates, all key bits
    queue_req(OP_LOOKUP, 16'h0000);
    queue_req(OP_INSERT, 16'hFFFF);
    queue_req(OP_INSERT, 16'h000F);
    queue_req(OP_INSERT, 16'h0000);
    queue_req(OP_LOOKUP, 16'h000F);
    queue_req(OP_LOOKUP, 16'h0000);
    queue_req(OP_LOOKUP, 16'h001F);
    queue_req(OP_INSERT, 16'h0000);
    queue_req(OP_LOOKUP, 16'hFFFF);
    queue_req(OP_INSERT, 16'h5555);
    queue_req(OP_INSERT, 16'hAAAA);
    queue_req(OP_LOOKUP, 16'h5555);
    queue_req(OP_LOOKUP, 16'hAAAA);
    queue_req(OP_LOOKUP, 16'h5550);
    queue_req(OP_LOOKUP, 16'h8000);

    // random: mostly lookups, keys partly drawn from earlier inserts, clustered homes to build long chains
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      op = ($urandom_range(99) < 25) ? OP_INSERT : OP_LOOKUP;
      r  = $urandom_range(99);
      if (r < 45 && known_keys.size() > 0) begin
        key = known_keys[$urandom_range(known_keys.size() - 1)];
      end else if (r < 75) begin
        nib_sel = 2'($urandom_range(3));
        key = {12'($urandom_range(16'hFFF)), 4'h0};
        case (nib_sel)
          2'd0: key[3:0] = 4'h0;
          2'd1: key[3:0] = 4'h1;
          2'd2: key[3:0] = 4'hE;
          default: key[3:0] = 4'hF;
        endcase
      end else begin
        key = IN_KEY_W'($urandom_range(16'hFFFF));
      end
      queue_req(op, key);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // wait for every beat to go in and every result to come back
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
